/* rtl/hed_pkg.sv */
// Shared constants and the named entity table for the HTML entity decoder.
package hed_pkg;

  localparam int MAX_ENTITY = 32;
  localparam int LEN_W      = $clog2(MAX_ENTITY + 1);
  localparam int ADDR_W     = $clog2(MAX_ENTITY);
  localparam int NAME_COUNT = 252;
  localparam int NAME_MAX   = 8;

  localparam logic [7:0]  CH_AMP   = 8'h26;
  localparam logic [7:0]  CH_SEMI  = 8'h3B;
  localparam logic [7:0]  CH_HASH  = 8'h23;
  localparam logic [7:0]  CH_X     = 8'h78;
  localparam logic [7:0]  CH_MINUS = 8'h2D;
  localparam logic [35:0] SAT_VALUE = 36'h07FFFFFFF;

  // Names are right-justified, zero padded at the top.
  localparam logic [63:0] NAME [NAME_COUNT] = '{
    "quot", "amp", "lt", "gt", "nbsp", "iexcl", "cent", "pound", "curren", "yen",
    "brvbar", "sect", "uml", "copy", "ordf", "laquo", "not", "shy", "reg", "macr",
    "deg", "plusmn", "sup2", "sup3", "acute", "micro", "para", "middot", "cedil",
    "sup1", "ordm", "raquo", "frac14", "frac12", "frac34", "iquest",
    "Agrave", "Aacute", "Acirc", "Atilde", "Auml", "Aring", "AElig", "Ccedil",
    "Egrave", "Eacute", "Ecirc", "Euml", "Igrave", "Iacute", "Icirc", "Iuml",
    "ETH", "Ntilde", "Ograve", "Oacute", "Ocirc", "Otilde", "Ouml", "times",
    "Oslash", "Ugrave", "Uacute", "Ucirc", "Uuml", "Yacute", "THORN", "szlig",
    "agrave", "aacute", "acirc", "atilde", "auml", "aring", "aelig", "ccedil",
    "egrave", "eacute", "ecirc", "euml", "igrave", "iacute", "icirc", "iuml",
    "eth", "ntilde", "ograve", "oacute", "ocirc", "otilde", "ouml", "divide",
    "oslash", "ugrave", "uacute", "ucirc", "uuml", "yacute", "thorn", "yuml",
    "OElig", "oelig", "Scaron", "scaron", "Yuml", "fnof", "circ", "tilde",
    "Alpha", "Beta", "Gamma", "Delta", "Epsilon", "Zeta", "Eta", "Theta", "Iota",
    "Kappa", "Lambda", "Mu", "Nu", "Xi", "Omicron", "Pi", "Rho", "Sigma", "Tau",
    "Upsilon", "Phi", "Chi", "Psi", "Omega",
    "alpha", "beta", "gamma", "delta", "epsilon", "zeta", "eta", "theta", "iota",
    "kappa", "lambda", "mu", "nu", "xi", "omicron", "pi", "rho", "sigmaf", "sigma",
    "tau", "upsilon", "phi", "chi", "psi", "omega", "thetasym", "upsih", "piv",
    "ensp", "emsp", "thinsp", "zwnj", "zwj", "lrm", "rlm", "ndash", "mdash",
    "lsquo", "rsquo", "sbquo", "ldquo", "rdquo", "bdquo", "dagger", "Dagger",
    "bull", "hellip", "permil", "prime", "Prime", "lsaquo", "rsaquo", "oline",
    "frasl", "euro", "image", "weierp", "real", "trade", "alefsym",
    "larr", "uarr", "rarr", "darr", "harr", "crarr", "lArr", "uArr", "rArr",
    "dArr", "hArr", "forall", "part", "exist", "empty", "nabla", "isin", "notin",
    "ni", "prod", "sum", "minus", "lowast", "radic", "prop", "infin", "ang",
    "and", "or", "cap", "cup", "int", "there4", "sim", "cong", "asymp", "ne",
    "equiv", "le", "ge", "sub", "sup", "nsub", "sube", "supe", "oplus", "otimes",
    "perp", "sdot", "lceil", "rceil", "lfloor", "rfloor", "lang", "rang", "loz",
    "spades", "clubs", "hearts", "diams"
  };

  localparam logic [15:0] CP [NAME_COUNT] = '{
    16'h0022, 16'h0026, 16'h003C, 16'h003E, 16'h00A0, 16'h00A1, 16'h00A2, 16'h00A3,
    16'h00A4, 16'h00A5, 16'h00A6, 16'h00A7, 16'h00A8, 16'h00A9, 16'h00AA, 16'h00AB,
    16'h00AC, 16'h00AD, 16'h00AE, 16'h00AF, 16'h00B0, 16'h00B1, 16'h00B2, 16'h00B3,
    16'h00B4, 16'h00B5, 16'h00B6, 16'h00B7, 16'h00B8, 16'h00B9, 16'h00BA, 16'h00BB,
    16'h00BC, 16'h00BD, 16'h00BE, 16'h00BF,
    16'h00C0, 16'h00C1, 16'h00C2, 16'h00C3, 16'h00C4, 16'h00C5, 16'h00C6, 16'h00C7,
    16'h00C8, 16'h00C9, 16'h00CA, 16'h00CB, 16'h00CC, 16'h00CD, 16'h00CE, 16'h00CF,
    16'h00D0, 16'h00D1, 16'h00D2, 16'h00D3, 16'h00D4, 16'h00D5, 16'h00D6, 16'h00D7,
    16'h00D8, 16'h00D9, 16'h00DA, 16'h00DB, 16'h00DC, 16'h00DD, 16'h00DE, 16'h00DF,
    16'h00E0, 16'h00E1, 16'h00E2, 16'h00E3, 16'h00E4, 16'h00E5, 16'h00E6, 16'h00E7,
    16'h00E8, 16'h00E9, 16'h00EA, 16'h00EB, 16'h00EC, 16'h00ED, 16'h00EE, 16'h00EF,
    16'h00F0, 16'h00F1, 16'h00F2, 16'h00F3, 16'h00F4, 16'h00F5, 16'h00F6, 16'h00F7,
    16'h00F8, 16'h00F9, 16'h00FA, 16'h00FB, 16'h00FC, 16'h00FD, 16'h00FE, 16'h00FF,
    16'h0152, 16'h0153, 16'h0160, 16'h0161, 16'h0178, 16'h0192, 16'h02C6, 16'h02DC,
    16'h0391, 16'h0392, 16'h0393, 16'h0394, 16'h0395, 16'h0396, 16'h0397, 16'h0398,
    16'h0399, 16'h039A, 16'h039B, 16'h039C, 16'h039D, 16'h039E, 16'h039F, 16'h03A0,
    16'h03A1, 16'h03A3, 16'h03A4, 16'h03A5, 16'h03A6, 16'h03A7, 16'h03A8, 16'h03A9,
    16'h03B1, 16'h03B2, 16'h03B3, 16'h03B4, 16'h03B5, 16'h03B6, 16'h03B7, 16'h03B8,
    16'h03B9, 16'h03BA, 16'h03BB, 16'h03BC, 16'h03BD, 16'h03BE, 16'h03BF, 16'h03C0,
    16'h03C1, 16'h03C2, 16'h03C3, 16'h03C4, 16'h03C5, 16'h03C6, 16'h03C7, 16'h03C8,
    16'h03C9, 16'h03D1, 16'h03D2, 16'h03D6,
    16'h2002, 16'h2003, 16'h2009, 16'h200C, 16'h200D, 16'h200E, 16'h200F, 16'h2013,
    16'h2014, 16'h2018, 16'h2019, 16'h201A, 16'h201C, 16'h201D, 16'h201E, 16'h2020,
    16'h2021, 16'h2022, 16'h2026, 16'h2030, 16'h2032, 16'h2033, 16'h2039, 16'h203A,
    16'h203E, 16'h2044, 16'h20AC, 16'h2111, 16'h2118, 16'h211C, 16'h2122, 16'h2135,
    16'h2190, 16'h2191, 16'h2192, 16'h2193, 16'h2194, 16'h21B5, 16'h21D0, 16'h21D1,
    16'h21D2, 16'h21D3, 16'h21D4, 16'h2200, 16'h2202, 16'h2203, 16'h2205, 16'h2207,
    16'h2208, 16'h2209, 16'h220B, 16'h220F, 16'h2211, 16'h2212, 16'h2217, 16'h221A,
    16'h221D, 16'h221E, 16'h2220, 16'h2227, 16'h2228, 16'h2229, 16'h222A, 16'h222B,
    16'h2234, 16'h223C, 16'h2245, 16'h2248, 16'h2260, 16'h2261, 16'h2264, 16'h2265,
    16'h2282, 16'h2283, 16'h2284, 16'h2286, 16'h2287, 16'h2295, 16'h2297, 16'h22A5,
    16'h22C5, 16'h2308, 16'h2309, 16'h230A, 16'h230B, 16'h2329, 16'h232A, 16'h25CA,
    16'h2660, 16'h2663, 16'h2665, 16'h2666
  };

  // Count the non-zero characters of a padded name.
  function automatic logic [3:0] name_length(input logic [63:0] s);
    logic [3:0] n;
    n = 4'd0;
    for (int k = 0; k < NAME_MAX; k++) begin
      if (s[8*k +: 8] != 8'h00) n = n + 4'd1;
    end
    return n;
  endfunction

  // Character p of a name, counted from the left.
  function automatic logic [7:0] name_char(input logic [63:0] s, input logic [3:0] l,
                                           input logic [2:0] p);
    logic [3:0] pos;
    logic [63:0] sh;
    pos = l - 4'd1 - {1'b0, p};
    sh  = s >> {pos[2:0], 3'b000};
    return sh[7:0];
  endfunction

endpackage

/* rtl/html_entity_decoder.sv */
// HTML entity decoder: passes text bytes, resolves entities into UTF-8 bytes.
//
//  channel | dir | tdata        | tlast       | tuser
//  s_*     | in  | text_byte    | end_of_text | -
//  m_*     | out | out_byte     | run_last    | text_done
//
// A plain byte is loaded into the output word when the output register drains. An entity byte
// is written into the entity memory as it is accepted. A resolved entity passes through lookup
// (ST_RESOLVE) and encode (ST_ENCODE), then sends its UTF-8 bytes one by one; a raw flush
// alternates a memory read and an output per buffered byte, as the memory read is registered.
// Reset clears control state only; the memory holds no reset value.
// A stall on m_tready holds the output word, input acceptance and the byte-emitting states.
module html_entity_decoder
  import hed_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] text_byte
  input  logic       s_tlast,   // end_of_text
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic       m_tlast,   // run_last
  output logic       m_tuser    // [0] text_done
);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_RESOLVE = 3'd1;
  localparam logic [2:0] ST_ENCODE  = 3'd2;
  localparam logic [2:0] ST_UTF     = 3'd3;
  localparam logic [2:0] ST_RAW_RD  = 3'd4;
  localparam logic [2:0] ST_RAW_OUT = 3'd5;

  logic [2:0]       state;
  logic [LEN_W-1:0] len;
  logic             in_entity;
  logic             hash, hex, stop, minus, eot_r;
  logic [30:0]      numval;
  logic [30:0]      code;
  logic [NAME_COUNT-1:0] cand;
  logic [2:0]       nbytes;
  logic [7:0]       ubytes [6];
  logic [LEN_W-1:0] idx;
  logic [7:0]       rd_data;
  logic [7:0]       ebuf [MAX_ENTITY];

  logic             out_free, acc, out_load;
  logic             mem_we, mem_re;
  logic [ADDR_W-1:0] wr_addr;
  logic [LEN_W-1:0] len_next;
  logic [NAME_COUNT-1:0] cand_next, match;
  logic [15:0]      cp_sel;
  logic             is_start, is_dpos, dvalid;
  logic [3:0]       dval;
  logic [35:0]      acc_val;
  logic [2:0]       enc_n;
  logic [7:0]       enc_b [6];

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE) && out_free;
  assign acc      = s_tvalid && s_tready;
  assign len_next = len + LEN_W'(1);
  assign wr_addr  = in_entity ? len[ADDR_W-1:0] : '0;
  assign mem_we   = acc && (in_entity || (s_tdata == CH_AMP && !s_tlast));
  assign mem_re   = (state == ST_RAW_RD);

  // Load a new output word: a plain byte, a UTF-8 byte or a raw byte.
  assign out_load = out_free &&
                    ((acc && !in_entity && !(s_tdata == CH_AMP && !s_tlast)) ||
                     (state == ST_UTF) || (state == ST_RAW_OUT));

  // Entity memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) ebuf[wr_addr] <= s_tdata;
    if (mem_re) rd_data <= ebuf[idx[ADDR_W-1:0]];
  end

  // Digit of the current byte in the active base.
  always_comb begin
    dvalid = 1'b0;
    dval   = 4'd0;
    if (s_tdata >= 8'h30 && s_tdata <= 8'h39) begin
      dvalid = 1'b1;
      dval   = 4'(s_tdata - 8'h30);
    end else if (hex && s_tdata >= 8'h61 && s_tdata <= 8'h66) begin
      dvalid = 1'b1;
      dval   = 4'(s_tdata - 8'h57);
    end else if (hex && s_tdata >= 8'h41 && s_tdata <= 8'h46) begin
      dvalid = 1'b1;
      dval   = 4'(s_tdata - 8'h37);
    end
  end

  // Digits start right after "&#" or "&#x".
  assign is_start = hash && ((len == LEN_W'(2) && s_tdata != CH_X) ||
                             (len == LEN_W'(3) && hex));
  assign is_dpos  = hash && !stop && (len >= LEN_W'(3) ||
                                      (len == LEN_W'(2) && s_tdata != CH_X));

  always_comb begin
    acc_val = hex ? {1'b0, numval, 4'b0000}
                  : ({2'b00, numval, 3'b000} + {4'b0000, numval, 1'b0});
    acc_val = acc_val + {32'd0, dval};
    if (acc_val > SAT_VALUE) acc_val = SAT_VALUE;
  end

  // Narrow the name candidates by one character per buffered byte.
  always_comb begin
    logic [LEN_W-1:0] p;
    logic [3:0] nl;
    p = len - LEN_W'(1);
    for (int i = 0; i < NAME_COUNT; i++) begin
      nl = name_length(NAME[i]);
      cand_next[i] = cand[i] && (p < LEN_W'(NAME_MAX)) && (p < LEN_W'(nl)) &&
                     (name_char(NAME[i], nl, p[2:0]) == s_tdata);
    end
  end

  // Names are unique, so at most one candidate of the right length survives.
  always_comb begin
    cp_sel = 16'h0000;
    for (int i = 0; i < NAME_COUNT; i++) begin
      match[i] = cand[i] && (LEN_W'(name_length(NAME[i])) == len - LEN_W'(2));
      if (match[i]) cp_sel = cp_sel | CP[i];
    end
  end

  // Legacy UTF-8 of up to six bytes.
  always_comb begin
    logic [35:0] v;
    logic [35:0] sh;
    v = {5'b0, code};
    if (code < 31'h80)           enc_n = 3'd1;
    else if (code < 31'h800)     enc_n = 3'd2;
    else if (code < 31'h10000)   enc_n = 3'd3;
    else if (code < 31'h200000)  enc_n = 3'd4;
    else if (code < 31'h4000000) enc_n = 3'd5;
    else                         enc_n = 3'd6;
    sh = v >> (6 * (32'(enc_n) - 1));
    enc_b[0] = (enc_n == 3'd1) ? v[7:0] : ((8'hFF << (4'd8 - {1'b0, enc_n})) | sh[7:0]);
    for (int k = 1; k < 6; k++) begin
      sh = v >> (6 * (32'(enc_n) - 1 - k));
      enc_b[k] = 8'h80 | {2'b00, sh[5:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      len       <= '0;
      in_entity <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      if (out_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (acc) begin
            eot_r <= s_tlast;
            if (!in_entity) begin
              if (s_tdata == CH_AMP && !s_tlast) begin
                len       <= LEN_W'(1);
                in_entity <= 1'b1;
                hash      <= 1'b0;
                hex       <= 1'b0;
                stop      <= 1'b0;
                minus     <= 1'b0;
                numval    <= '0;
                cand      <= '1;
              end else begin
                m_tdata  <= s_tdata;
                m_tlast  <= 1'b1;
                m_tuser  <= s_tlast;
              end
            end else begin
              len <= len_next;
              if (len == LEN_W'(1)) hash <= (s_tdata == CH_HASH);
              if (hash && len == LEN_W'(2) && s_tdata == CH_X) hex <= 1'b1;
              if (is_dpos) begin
                if (is_start && s_tdata == CH_MINUS) begin
                  minus <= 1'b1;
                  stop  <= 1'b1;
                end else if (dvalid) begin
                  numval <= acc_val[30:0];
                end else begin
                  stop <= 1'b1;
                end
              end
              if (s_tdata == CH_SEMI) begin
                in_entity <= 1'b0;
                state     <= ST_RESOLVE;
              end else begin
                cand <= cand_next;
                if (len_next >= LEN_W'(MAX_ENTITY) || s_tlast) begin
                  in_entity <= 1'b0;
                  idx       <= '0;
                  state     <= ST_RAW_RD;
                end
              end
            end
          end
        end
        ST_RESOLVE: begin
          idx <= '0;
          if (hash) begin
            if (minus) begin
              len   <= '0;
              state <= ST_IDLE;
            end else begin
              code  <= numval;
              state <= ST_ENCODE;
            end
          end else if (|match) begin
            code  <= {15'd0, cp_sel};
            state <= ST_ENCODE;
          end else begin
            state <= ST_RAW_RD;
          end
        end
        ST_ENCODE: begin
          nbytes <= enc_n;
          for (int k = 0; k < 6; k++) ubytes[k] <= enc_b[k];
          state <= ST_UTF;
        end
        ST_UTF: begin
          if (out_free) begin
            m_tdata  <= ubytes[idx[2:0]];
            m_tlast  <= (idx[2:0] == nbytes - 3'd1);
            m_tuser  <= eot_r && (idx[2:0] == nbytes - 3'd1);
            if (idx[2:0] == nbytes - 3'd1) begin
              len   <= '0;
              state <= ST_IDLE;
            end else begin
              idx <= idx + LEN_W'(1);
            end
          end
        end
        ST_RAW_RD: begin
          state <= ST_RAW_OUT;
        end
        ST_RAW_OUT: begin
          if (out_free) begin
            m_tdata  <= rd_data;
            m_tlast  <= (idx == len - LEN_W'(1));
            m_tuser  <= eot_r && (idx == len - LEN_W'(1));
            if (idx == len - LEN_W'(1)) begin
              len   <= '0;
              state <= ST_IDLE;
            end else begin
              idx   <= idx + LEN_W'(1);
              state <= ST_RAW_RD;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // The buffer length never runs past the memory.
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    len <= LEN_W'(MAX_ENTITY))
    else $error("entity length past buffer depth");

  // A byte taken inside an entity always finds a free entry.
  a_room: assert property (@(posedge clk) disable iff (rst)
    (acc && in_entity) |-> (len < LEN_W'(MAX_ENTITY)))
    else $error("entity byte with full buffer");

  // The name lookup never resolves to two entries.
  a_one_match: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RESOLVE) |-> $onehot0(match))
    else $error("several names matched");

endmodule
